/* hw/rtl/radix_trie_prefix_lookup_assert.svh */
// Assertion macros shared by the radix trie lookup checker.
`ifndef RADIX_TRIE_PREFIX_LOOKUP_ASSERT_SVH
`define RADIX_TRIE_PREFIX_LOOKUP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RTPL_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define RTPL_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/rtpl_pkg.sv */
// Types, codes and constants of the radix trie prefix lookup block.
`timescale 1ns / 1ps
package rtpl_pkg;

  localparam int unsigned NODE_DEPTH_DEF = 65536;
  localparam int unsigned LEAF_DEPTH_DEF = 65536;

  localparam int unsigned IN_DATA_W  = 304;
  localparam int unsigned IN_USER_W  = 3;
  localparam int unsigned OUT_DATA_W = 64;
  localparam int unsigned OUT_USER_W = 1;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 17;

  localparam int unsigned KEY_W   = 128;
  localparam int unsigned DEPTH_W = 8;
  localparam int unsigned NODE_W  = 96;
  localparam int unsigned LEAF_W  = 64;

  localparam logic [DEPTH_W-1:0] V4_BITS = 8'd32;
  localparam logic [DEPTH_W-1:0] V6_BITS = 8'd128;

  localparam logic [31:0] NET_NONE_MASK = 32'h8000_0000;
  localparam logic [31:0] MAPPED_TAG    = 32'h0000_FFFF;

  localparam logic [CFG_IDX_W-1:0] CFG_IPV4_ROOT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NODE_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LEAF_COUNT = 2'd2;

  typedef enum logic [1:0] {
    OP_NODE   = 2'd0,
    OP_LEAF   = 2'd1,
    OP_LOOKUP = 2'd2
  } rtpl_op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_DONE
  } rtpl_state_e;

  // Controller to datapath.
  typedef struct packed {
    logic wr_node;
    logic wr_leaf;
    logic start;
    logic step;
    logic leaf_rd;
    logic miss;
    logic push;
  } rtpl_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic start_ok;
    logic walk_end;
    logic child_ok;
    logic leaf_ok;
    logic out_free;
  } rtpl_sts_t;

endpackage

/* hw/rtl/rtpl_ram.sv */
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
module rtpl_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hw/rtl/rtpl_ctrl.sv */
// Controller state machine for the trie walk.
`timescale 1ns / 1ps
module rtpl_ctrl import rtpl_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic [1:0] in_op_i,
  output logic       in_ready_o,
  input  rtpl_sts_t  sts_i,
  output rtpl_cmd_t  cmd_o
);

  rtpl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i && (in_op_i == OP_LOOKUP)) begin
          state_d = sts_i.start_ok ? ST_WALK : ST_DONE;
        end
      end
      ST_WALK: begin
        if (sts_i.walk_end || !sts_i.child_ok) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (sts_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          unique case (in_op_i)
            OP_NODE:   cmd_o.wr_node = 1'b1;
            OP_LEAF:   cmd_o.wr_leaf = 1'b1;
            OP_LOOKUP: begin
              cmd_o.start = sts_i.start_ok;
              cmd_o.miss  = !sts_i.start_ok;
            end
            default: ;
          endcase
        end
      end
      ST_WALK: begin
        if (sts_i.walk_end) begin
          cmd_o.leaf_rd = sts_i.leaf_ok;
          cmd_o.miss    = !sts_i.leaf_ok;
        end else begin
          cmd_o.step = sts_i.child_ok;
          cmd_o.miss = !sts_i.child_ok;
        end
      end
      ST_DONE: begin
        cmd_o.push = sts_i.out_free;
      end
      default: ;
    endcase
  end

endmodule

/* hw/rtl/rtpl_datapath.sv */
// Datapath: config registers, node and leaf stores, walk state, output register.
`timescale 1ns / 1ps
module rtpl_datapath import rtpl_pkg::*; #(
  parameter int unsigned NODE_DEPTH = NODE_DEPTH_DEF,
  parameter int unsigned LEAF_DEPTH = LEAF_DEPTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic [15:0]           entry_index_i,
  input  logic                  is_ipv6_i,
  input  logic [63:0]           address_high_i,
  input  logic [63:0]           address_low_i,
  input  logic [31:0]           child_zero_i,
  input  logic [31:0]           child_one_i,
  input  logic [31:0]           network_word_i,
  input  logic [15:0]           country_code_i,
  input  logic [31:0]           asn_value_i,
  input  logic [15:0]           leaf_flags_i,
  input  rtpl_cmd_t             cmd_i,
  output rtpl_sts_t             sts_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic                  out_found_o,
  output logic [15:0]           out_country_o,
  output logic [31:0]           out_asn_o,
  output logic [15:0]           out_flags_o
);

  localparam int unsigned NODE_AW = (NODE_DEPTH > 1) ? $clog2(NODE_DEPTH) : 1;
  localparam int unsigned LEAF_AW = (LEAF_DEPTH > 1) ? $clog2(LEAF_DEPTH) : 1;
  localparam logic [31:0] NodeLimit = 32'(NODE_DEPTH);
  localparam logic [31:0] LeafLimit = 32'(LEAF_DEPTH);

  logic [15:0] root_q;
  logic [16:0] node_cnt_q, leaf_cnt_q;
  logic [31:0] node_cnt_ext, leaf_cnt_ext;

  logic [KEY_W-1:0]   key_q;
  logic               v4_q;
  logic [DEPTH_W-1:0] depth_q;
  logic               have_q;
  logic [31:0]        best_q;
  logic               found_q;

  logic               out_valid_q, out_found_q;
  logic [15:0]        out_country_q, out_flags_q;
  logic [31:0]        out_asn_q;

  logic               lookup_v4;
  logic [31:0]        start_node, idx_ext;
  logic [NODE_W-1:0]  node_rdata;
  logic [LEAF_W-1:0]  leaf_rdata;
  logic [31:0]        kid0, kid1, net, child;
  logic               net_hit, have_eff;
  logic [31:0]        best_eff;
  logic               depth_end;

  // Configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      root_q     <= '0;
      node_cnt_q <= '0;
      leaf_cnt_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_IPV4_ROOT:  root_q     <= cfg_data_i[15:0];
        CFG_NODE_COUNT: node_cnt_q <= cfg_data_i;
        CFG_LEAF_COUNT: leaf_cnt_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign node_cnt_ext = {15'd0, node_cnt_q};
  assign leaf_cnt_ext = {15'd0, leaf_cnt_q};
  assign idx_ext      = {16'd0, entry_index_i};

  // IPv4 and IPv4-mapped addresses walk 32 bits from the IPv4 root
  assign lookup_v4  = !is_ipv6_i ||
                      ((address_high_i == 64'd0) && (address_low_i[63:32] == MAPPED_TAG));
  assign start_node = lookup_v4 ? {16'd0, root_q} : 32'd0;

  assign kid0 = node_rdata[31:0];
  assign kid1 = node_rdata[63:32];
  assign net  = node_rdata[95:64];

  assign net_hit   = (net & NET_NONE_MASK) == 32'd0;
  assign have_eff  = have_q | net_hit;
  assign best_eff  = net_hit ? net : best_q;
  assign child     = key_q[KEY_W-1] ? kid1 : kid0;
  assign depth_end = depth_q == (v4_q ? V4_BITS : V6_BITS);

  always_comb begin
    sts_o          = '0;
    sts_o.start_ok = (start_node < node_cnt_ext) && (start_node < NodeLimit);
    sts_o.walk_end = depth_end || (child == 32'd0);
    sts_o.child_ok = (child < node_cnt_ext) && (child < NodeLimit);
    sts_o.leaf_ok  = have_eff && (best_eff < leaf_cnt_ext) && (best_eff < LeafLimit);
    sts_o.out_free = !out_valid_q || out_ready_i;
  end

  rtpl_ram #(
    .WIDTH (NODE_W),
    .DEPTH (NODE_DEPTH)
  ) u_node_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.wr_node && (idx_ext < NodeLimit)),
    .waddr_i (idx_ext[NODE_AW-1:0]),
    .wdata_i ({network_word_i, child_one_i, child_zero_i}),
    .re_i    (cmd_i.start || cmd_i.step),
    .raddr_i (cmd_i.start ? start_node[NODE_AW-1:0] : child[NODE_AW-1:0]),
    .rdata_o (node_rdata)
  );

  rtpl_ram #(
    .WIDTH (LEAF_W),
    .DEPTH (LEAF_DEPTH)
  ) u_leaf_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.wr_leaf && (idx_ext < LeafLimit)),
    .waddr_i (idx_ext[LEAF_AW-1:0]),
    .wdata_i ({leaf_flags_i, asn_value_i, country_code_i}),
    .re_i    (cmd_i.leaf_rd),
    .raddr_i (best_eff[LEAF_AW-1:0]),
    .rdata_o (leaf_rdata)
  );

  // Walk state: key shifts left so the bit in use is always the MSB
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      key_q  <= lookup_v4 ? {address_low_i[31:0], 96'd0} : {address_high_i, address_low_i};
      best_q <= '0;
    end else if (cmd_i.step) begin
      key_q  <= {key_q[KEY_W-2:0], 1'b0};
      best_q <= best_eff;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q    <= 1'b0;
      depth_q <= '0;
      have_q  <= 1'b0;
      found_q <= 1'b0;
    end else begin
      if (cmd_i.start) begin
        v4_q    <= lookup_v4;
        depth_q <= '0;
        have_q  <= 1'b0;
      end else if (cmd_i.step) begin
        depth_q <= depth_q + DEPTH_W'(1);
        have_q  <= have_eff;
      end
      if (cmd_i.leaf_rd) begin
        found_q <= 1'b1;
      end else if (cmd_i.miss) begin
        found_q <= 1'b0;
      end
    end
  end

  // Output register; leaf RAM data holds until the next leaf read
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      out_found_q <= 1'b0;
    end else if (cmd_i.push) begin
      out_valid_q <= 1'b1;
      out_found_q <= found_q;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      out_country_q <= found_q ? leaf_rdata[15:0]  : 16'd0;
      out_asn_q     <= found_q ? leaf_rdata[47:16] : 32'd0;
      out_flags_q   <= found_q ? leaf_rdata[63:48] : 16'd0;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_found_o   = out_found_q;
  assign out_country_o = out_country_q;
  assign out_asn_o     = out_asn_q;
  assign out_flags_o   = out_flags_q;

endmodule

/* hw/rtl/radix_trie_prefix_lookup.sv */
// Top level of the binary radix trie longest-prefix lookup block.
// Usage:
//   s_axis carries one word per command: node write, leaf write or lookup.
//   Node and leaf writes load the trie stores and produce no result;
//   ready stays high after them. Unused command codes are dropped.
//   A lookup walks the address MSB first, one node memory read per cycle:
//   a start step reads the root node, a walk step examines each node visited
//   (up to 33 for IPv4 or IPv4-mapped, up to 129 for IPv6), then a done step
//   loads the output register.
//   s_axis_tready is high only while no lookup is in flight.
//   m_axis gives one result word per lookup from an output register; a new
//   command is taken while that word waits. If the receiver stalls and the
//   register is still full, the next lookup holds at its end until it drains.
//   Config writes (cfg_we_i) are registered; issue them only while idle.
//   Reset clears the config registers and control state; the stores are not
//   cleared and must be written before they are read.
`timescale 1ns / 1ps
module radix_trie_prefix_lookup import rtpl_pkg::*; #(
  parameter int unsigned NODE_DEPTH = NODE_DEPTH_DEF,
  parameter int unsigned LEAF_DEPTH = LEAF_DEPTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Config write port
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  // Command channel
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // entry_index[15:0], address_high[79:16], address_low[143:80],
  // child_zero[175:144], child_one[207:176], network_word[239:208],
  // country_code[255:240], asn_value[287:256], leaf_flags[303:288]
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // operation[1:0], is_ipv6[2]
  input  logic [IN_USER_W-1:0]  s_axis_tuser,
  // Result channel
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // match_country[15:0], match_asn[47:16], match_flags[63:48]
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  // found[0]
  output logic [OUT_USER_W-1:0] m_axis_tuser
);

  rtpl_cmd_t   cmd;
  rtpl_sts_t   sts;
  logic        out_found;
  logic [15:0] out_country, out_flags;
  logic [31:0] out_asn;

  rtpl_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_op_i    (s_axis_tuser[1:0]),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  rtpl_datapath #(
    .NODE_DEPTH (NODE_DEPTH),
    .LEAF_DEPTH (LEAF_DEPTH)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .entry_index_i  (s_axis_tdata[15:0]),
    .is_ipv6_i      (s_axis_tuser[2]),
    .address_high_i (s_axis_tdata[79:16]),
    .address_low_i  (s_axis_tdata[143:80]),
    .child_zero_i   (s_axis_tdata[175:144]),
    .child_one_i    (s_axis_tdata[207:176]),
    .network_word_i (s_axis_tdata[239:208]),
    .country_code_i (s_axis_tdata[255:240]),
    .asn_value_i    (s_axis_tdata[287:256]),
    .leaf_flags_i   (s_axis_tdata[303:288]),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .out_valid_o    (m_axis_tvalid),
    .out_ready_i    (m_axis_tready),
    .out_found_o    (out_found),
    .out_country_o  (out_country),
    .out_asn_o      (out_asn),
    .out_flags_o    (out_flags)
  );

  assign m_axis_tdata = {out_flags, out_asn, out_country};
  assign m_axis_tuser = out_found;

endmodule

/* hw/rtl/rtpl_checker.sv */
// Port-level checker for the radix trie lookup block, bound to the top level.
`timescale 1ns / 1ps
`include "radix_trie_prefix_lookup_assert.svh"
module rtpl_checker import rtpl_pkg::*; (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  s_axis_tvalid,
  input logic                  s_axis_tready,
  input logic [IN_USER_W-1:0]  s_axis_tuser,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [OUT_DATA_W-1:0] m_axis_tdata,
  input logic [OUT_USER_W-1:0] m_axis_tuser
);

  logic lookup_acc, other_acc;

  assign lookup_acc = s_axis_tvalid && s_axis_tready && (s_axis_tuser[1:0] == OP_LOOKUP);
  assign other_acc  = s_axis_tvalid && s_axis_tready && (s_axis_tuser[1:0] != OP_LOOKUP);

  // A stalled result word holds
  `RTPL_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready,
    m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "result word changed under stall")

  // A miss carries all-zero match fields
  `RTPL_ASSERT_NOW(a_miss_zero, clk_i, rst_ni, m_axis_tvalid && !m_axis_tuser[0],
    m_axis_tdata == '0, "miss with nonzero match data")

  // A lookup occupies the block for at least the next cycle
  `RTPL_ASSERT_NEXT(a_lookup_busy, clk_i, rst_ni, lookup_acc,
    !s_axis_tready, "command accepted right after a lookup")

  // Writes and unused codes leave the block ready
  `RTPL_ASSERT_NEXT(a_write_idle, clk_i, rst_ni, other_acc,
    s_axis_tready, "block busy after a write")

endmodule

bind radix_trie_prefix_lookup rtpl_checker u_rtpl_checker (.*);
